// ----- sv/cbf_pkg.sv -----
// shared types and constants of the counting bloom filter
`default_nettype none
package cbf_pkg;

	localparam int HASH_W      = 64;
	localparam int OP_W        = 2;
	localparam int CNT_W       = 8;
	localparam int SPILL_CNT_W = 16;
	localparam int HB_W        = 7;
	localparam int CB_W        = 4;
	localparam int OUT_NZ_W    = 11;
	localparam int OUT_W       = 16;
	localparam int CFG_IDX_W   = 1;
	localparam int HB_MAX      = 64;
	localparam int CB_MAX      = 8;

	localparam logic [CFG_IDX_W-1:0] CFG_HASH_BITS    = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_COUNTER_BITS = 1'd1;

	typedef enum logic [OP_W-1:0] {
		OP_ADD = 2'd0,
		OP_DEL = 2'd1,
		OP_CHK = 2'd2,
		OP_NOP = 2'd3
	} op_t;

	typedef enum logic [10:0] {
		ST_IDLE  = 11'b000_0000_0001,
		ST_CLEAR = 11'b000_0000_0010,
		ST_RD    = 11'b000_0000_0100,
		ST_CHK   = 11'b000_0000_1000,
		ST_MOD   = 11'b000_0001_0000,
		ST_PRD   = 11'b000_0010_0000,
		ST_PCHK  = 11'b000_0100_0000,
		ST_BRD   = 11'b000_1000_0000,
		ST_BCHK  = 11'b001_0000_0000,
		ST_BEND  = 11'b010_0000_0000,
		ST_DONE  = 11'b100_0000_0000
	} state_t;

	typedef struct packed {
		logic ld_item;
		logic clr_wr;
		logic next_slice;
		logic cap_val;
		logic val_hold;
		logic cnt_inc;
		logic cnt_dec;
		logic miss;
		logic mod_start;
		logic probe_start;
		logic probe_next;
		logic sp_new;
		logic sp_inc;
		logic sp_dec;
		logic set_full;
		logic shift_start;
		logic shift_move;
		logic shift_next;
		logic shift_end;
		logic out_load;
	} cmd_t;

	typedef struct packed {
		logic clr_last;
		logic slice_ok;
		op_t  op;
		logic cnt_zero;
		logic cnt_at_max;
		logic mod_done;
		logic ent_empty;
		logic ent_match;
		logic ent_one;
		logic probe_last;
		logic do_move;
		logic out_busy;
	} status_t;

endpackage
`default_nettype wire

// ----- sv/cbf_ram.sv -----
// generic simple dual-port ram with registered read
`default_nettype none
module cbf_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule
`default_nettype wire

// ----- sv/cbf_dp.sv -----
// datapath: config, counter and overflow rams, probe and shift registers, result register
`default_nettype none
module cbf_dp #(
	parameter int NUM_POINTS     = 1024,
	parameter int CHUNK_STRIDE   = 11,
	parameter int OVERFLOW_DEPTH = 64
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire cbf_pkg::cmd_t                    cmd,
	output cbf_pkg::status_t                      sts,
	input  wire logic                             cfg_valid,
	output logic                                  cfg_ready,
	input  wire logic [cbf_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  wire logic [cbf_pkg::HB_W-1:0]         cfg_data,
	input  wire logic [cbf_pkg::HASH_W-1:0]       s_tdata,
	input  wire logic [cbf_pkg::OP_W-1:0]         s_tuser,
	output logic                                  m_tvalid,
	input  wire logic                             m_tready,
	output logic [cbf_pkg::OUT_W-1:0]             m_tdata
);
	import cbf_pkg::*;

	localparam int PW    = $clog2(NUM_POINTS);
	localparam int SW    = $clog2(OVERFLOW_DEPTH);
	localparam int NZW   = $clog2(NUM_POINTS + 1);
	localparam int CLR_N = (NUM_POINTS > OVERFLOW_DEPTH) ? NUM_POINTS : OVERFLOW_DEPTH;
	localparam int CW    = $clog2(CLR_N);
	localparam int EW    = SPILL_CNT_W + SW + PW;
	localparam int RW    = (PW > SW) ? PW : SW + 1;
	localparam int MULW  = 2 * PW + SW + 1;
	localparam int RECIP = (1 << PW) / OVERFLOW_DEPTH;

	// configuration
	logic [HB_W-1:0] hbits_q;
	logic [CB_W-1:0] cbits_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hbits_q <= HB_W'(HB_MAX);
			cbits_q <= CB_W'(CB_MAX);
		end else if (cfg_valid) begin
			unique case (cfg_index)
				CFG_HASH_BITS:    hbits_q <= cfg_data;
				CFG_COUNTER_BITS: cbits_q <= cfg_data[CB_W-1:0];
				default: ;
			endcase
		end
	end

	logic [HB_W-1:0]  hb_eff;
	logic [CB_W-1:0]  cb_eff;
	logic [CNT_W-1:0] maxv;

	always_comb begin
		hb_eff = (hbits_q > HB_W'(HB_MAX)) ? HB_W'(HB_MAX) : hbits_q;
		if (cbits_q == '0) begin
			cb_eff = CB_W'(1);
		end else if (cbits_q > CB_W'(CB_MAX)) begin
			cb_eff = CB_W'(CB_MAX);
		end else begin
			cb_eff = cbits_q;
		end
		maxv = CNT_W'((9'd1 << cb_eff) - 9'd1);
	end

	// item registers
	logic [HASH_W-1:0] hash_q;
	op_t               op_q;
	logic [7:0]        off_q;
	logic              present_q;
	logic              full_q;
	logic [CNT_W-1:0]  val_q;
	logic [NZW-1:0]    nz_q;
	logic [CW-1:0]     clr_q;
	logic [PW-1:0]     idx;
	logic [CNT_W-1:0]  cnt_rdata;

	assign idx = hash_q[PW-1:0] & PW'(NUM_POINTS - 1);

	always_ff @(posedge clk) begin
		if (cmd.ld_item) begin
			hash_q <= s_tdata;
			op_q   <= op_t'(s_tuser);
		end else if (cmd.next_slice) begin
			hash_q <= hash_q >> CHUNK_STRIDE;
		end
		if (cmd.cap_val) begin
			val_q <= cnt_rdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			off_q     <= '0;
			present_q <= 1'b0;
			full_q    <= 1'b0;
			clr_q     <= '0;
		end else begin
			if (cmd.ld_item) begin
				off_q <= '0;
			end else if (cmd.next_slice) begin
				off_q <= off_q + 8'(CHUNK_STRIDE);
			end
			if (cmd.ld_item) begin
				present_q <= 1'b1;
			end else if (cmd.miss) begin
				present_q <= 1'b0;
			end
			if (cmd.ld_item) begin
				full_q <= 1'b0;
			end else if (cmd.set_full) begin
				full_q <= 1'b1;
			end
			if (cmd.clr_wr) begin
				clr_q <= clr_q + CW'(1);
			end
		end
	end

	// counter ram
	logic [CNT_W-1:0] val;
	logic             cnt_we;
	logic [PW-1:0]    cnt_waddr;
	logic [CNT_W-1:0] cnt_wdata;
	logic             clr_in_np;
	logic             clr_in_sp;

	assign clr_in_np = {1'b0, clr_q} < (CW + 1)'(NUM_POINTS);
	assign clr_in_sp = {1'b0, clr_q} < (CW + 1)'(OVERFLOW_DEPTH);
	assign val       = cmd.val_hold ? val_q : cnt_rdata;

	always_comb begin
		if (cmd.clr_wr) begin
			cnt_we    = clr_in_np;
			cnt_waddr = clr_q[PW-1:0];
			cnt_wdata = '0;
		end else begin
			cnt_we    = cmd.cnt_inc | cmd.cnt_dec;
			cnt_waddr = idx;
			cnt_wdata = cmd.cnt_inc ? val + CNT_W'(1) : val - CNT_W'(1);
		end
	end

	cbf_ram #(
		.WIDTH(CNT_W),
		.DEPTH(NUM_POINTS)
	) u_cnt_ram (
		.clk  (clk),
		.we   (cnt_we),
		.waddr(cnt_waddr),
		.wdata(cnt_wdata),
		.raddr(idx),
		.rdata(cnt_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			nz_q <= '0;
		end else if (cmd.cnt_inc && val == '0) begin
			nz_q <= nz_q + NZW'(1);
		end else if (cmd.cnt_dec && val == CNT_W'(1)) begin
			nz_q <= nz_q - NZW'(1);
		end
	end

	// home slot: quotient estimate by reciprocal multiply, registered on mod_start,
	// remainder with one correcting subtract in the next
	logic [SW-1:0]   rem_q;
	logic [PW-1:0]   quo_q;
	logic            mod_busy_q;
	logic [MULW-1:0] quo_prod;
	logic [MULW-1:0] quo_back;
	logic [RW-1:0]   rem_raw;
	logic [RW-1:0]   rem_nx;

	assign quo_prod = MULW'(idx) * MULW'(RECIP);
	assign quo_back = MULW'(quo_q) * MULW'(OVERFLOW_DEPTH);
	assign rem_raw  = RW'(idx) - quo_back[RW-1:0];
	assign rem_nx   = (rem_raw >= RW'(OVERFLOW_DEPTH)) ?
		rem_raw - RW'(OVERFLOW_DEPTH) : rem_raw;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mod_busy_q <= 1'b0;
		end else begin
			mod_busy_q <= cmd.mod_start;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.mod_start) begin
			quo_q <= quo_prod[PW +: PW];
		end
		if (mod_busy_q) begin
			rem_q <= rem_nx[SW-1:0];
		end
	end

	// overflow table
	logic [EW-1:0]          sp_rdata;
	logic [SPILL_CNT_W-1:0] ent_cnt;
	logic [SW-1:0]          ent_home;
	logic [PW-1:0]          ent_pt;
	logic [SW-1:0]          slot_q;
	logic [SW-1:0]          hole_q;
	logic [SW-1:0]          home_q;
	logic [SW-1:0]          k_q;
	logic [SW-1:0]          slot_inc;
	logic [SW:0]            d_home;
	logic [SW:0]            d_hole;
	logic                   sp_we;
	logic [SW-1:0]          sp_waddr;
	logic [EW-1:0]          sp_wdata;

	assign ent_cnt  = sp_rdata[SPILL_CNT_W-1:0];
	assign ent_home = sp_rdata[SPILL_CNT_W +: SW];
	assign ent_pt   = sp_rdata[SPILL_CNT_W + SW +: PW];
	assign slot_inc = (slot_q == SW'(OVERFLOW_DEPTH - 1)) ? '0 : slot_q + SW'(1);

	// wrapped distances of the probed slot from its home and from the hole
	assign d_home = (slot_q >= ent_home) ? {1'b0, slot_q} - {1'b0, ent_home} :
		{1'b0, slot_q} + (SW + 1)'(OVERFLOW_DEPTH) - {1'b0, ent_home};
	assign d_hole = (slot_q >= hole_q) ? {1'b0, slot_q} - {1'b0, hole_q} :
		{1'b0, slot_q} + (SW + 1)'(OVERFLOW_DEPTH) - {1'b0, hole_q};

	always_ff @(posedge clk) begin
		if (cmd.probe_start) begin
			slot_q <= rem_q;
			home_q <= rem_q;
			k_q    <= '0;
		end else if (cmd.shift_start) begin
			hole_q <= slot_q;
			slot_q <= slot_inc;
			k_q    <= SW'(1);
		end else begin
			if (cmd.shift_move) begin
				hole_q <= slot_q;
			end
			if (cmd.probe_next || cmd.shift_next) begin
				slot_q <= slot_inc;
				k_q    <= k_q + SW'(1);
			end
		end
	end

	always_comb begin
		sp_we    = 1'b1;
		sp_waddr = slot_q;
		sp_wdata = '0;
		if (cmd.clr_wr) begin
			sp_we    = clr_in_sp;
			sp_waddr = clr_q[SW-1:0];
		end else if (cmd.sp_new) begin
			sp_wdata = {idx, home_q, SPILL_CNT_W'(1)};
		end else if (cmd.sp_inc) begin
			sp_wdata = {ent_pt, ent_home,
				(ent_cnt == '1) ? ent_cnt : ent_cnt + SPILL_CNT_W'(1)};
		end else if (cmd.sp_dec) begin
			sp_wdata = {ent_pt, ent_home, ent_cnt - SPILL_CNT_W'(1)};
		end else if (cmd.shift_move) begin
			sp_waddr = hole_q;
			sp_wdata = sp_rdata;
		end else if (cmd.shift_end) begin
			sp_waddr = hole_q;
		end else begin
			sp_we = 1'b0;
		end
	end

	cbf_ram #(
		.WIDTH(EW),
		.DEPTH(OVERFLOW_DEPTH)
	) u_spill_ram (
		.clk  (clk),
		.we   (sp_we),
		.waddr(sp_waddr),
		.wdata(sp_wdata),
		.raddr(slot_q),
		.rdata(sp_rdata)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
		end else if (cmd.out_load) begin
			m_tvalid <= 1'b1;
		end else if (m_tready) begin
			m_tvalid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			m_tdata <= {(OUT_W - OUT_NZ_W - 2)'(0), full_q, OUT_NZ_W'(nz_q),
				(op_q == OP_CHK) && present_q};
		end
	end

	// status
	always_comb begin
		sts.clr_last   = (clr_q == CW'(CLR_N - 1));
		sts.slice_ok   = (off_q + 8'(CHUNK_STRIDE)) <= {1'b0, hb_eff};
		sts.op         = op_q;
		sts.cnt_zero   = (cnt_rdata == '0);
		sts.cnt_at_max = (cnt_rdata >= maxv);
		sts.mod_done   = !mod_busy_q;
		sts.ent_empty  = (ent_cnt == '0);
		sts.ent_match  = (ent_pt == idx);
		sts.ent_one    = (ent_cnt == SPILL_CNT_W'(1));
		sts.probe_last = (k_q == SW'(OVERFLOW_DEPTH - 1));
		sts.do_move    = (d_home >= d_hole);
		sts.out_busy   = m_tvalid && !m_tready;
	end

endmodule
`default_nettype wire

// ----- sv/cbf_ctrl.sv -----
// controller: sequences slices, overflow probing and backward-shift deletion
`default_nettype none
module cbf_ctrl (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             s_tvalid,
	output logic                  s_tready,
	input  wire cbf_pkg::status_t sts,
	output cbf_pkg::cmd_t         cmd
);
	import cbf_pkg::*;

	state_t state_q;
	state_t state_nx;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_nx;
		end
	end

	assign s_tready = (state_q == ST_IDLE);

	always_comb begin
		state_nx = state_q;
		cmd      = '0;
		unique case (state_q)
			ST_CLEAR: begin
				cmd.clr_wr = 1'b1;
				if (sts.clr_last) begin
					state_nx = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (s_tvalid) begin
					cmd.ld_item = 1'b1;
					state_nx    = ST_RD;
				end
			end
			ST_RD: begin
				if (!sts.slice_ok || sts.op == OP_NOP) begin
					state_nx = ST_DONE;
				end else begin
					state_nx = ST_CHK;
				end
			end
			ST_CHK: begin
				cmd.cap_val = 1'b1;
				state_nx    = ST_RD;
				case (sts.op)
					OP_ADD: begin
						if (!sts.cnt_at_max) begin
							cmd.cnt_inc    = 1'b1;
							cmd.next_slice = 1'b1;
						end else begin
							cmd.mod_start = 1'b1;
							state_nx      = ST_MOD;
						end
					end
					OP_DEL: begin
						if (sts.cnt_zero) begin
							cmd.next_slice = 1'b1;
						end else if (!sts.cnt_at_max) begin
							cmd.cnt_dec    = 1'b1;
							cmd.next_slice = 1'b1;
						end else begin
							cmd.mod_start = 1'b1;
							state_nx      = ST_MOD;
						end
					end
					OP_CHK: begin
						cmd.miss       = sts.cnt_zero;
						cmd.next_slice = 1'b1;
					end
					default: cmd.next_slice = 1'b1;
				endcase
			end
			ST_MOD: begin
				if (sts.mod_done) begin
					cmd.probe_start = 1'b1;
					state_nx        = ST_PRD;
				end
			end
			ST_PRD: state_nx = ST_PCHK;
			ST_PCHK: begin
				state_nx = ST_RD;
				if (sts.op == OP_ADD) begin
					if (sts.ent_empty) begin
						cmd.sp_new     = 1'b1;
						cmd.next_slice = 1'b1;
					end else if (sts.ent_match) begin
						cmd.sp_inc     = 1'b1;
						cmd.next_slice = 1'b1;
					end else if (sts.probe_last) begin
						cmd.set_full   = 1'b1;
						cmd.next_slice = 1'b1;
					end else begin
						cmd.probe_next = 1'b1;
						state_nx       = ST_PRD;
					end
				end else begin
					// not in the table: the counter itself goes down
					if (sts.ent_empty || (!sts.ent_match && sts.probe_last)) begin
						cmd.val_hold   = 1'b1;
						cmd.cnt_dec    = 1'b1;
						cmd.next_slice = 1'b1;
					end else if (sts.ent_match && !sts.ent_one) begin
						cmd.sp_dec     = 1'b1;
						cmd.next_slice = 1'b1;
					end else if (sts.ent_match) begin
						cmd.shift_start = 1'b1;
						state_nx        = ST_BRD;
					end else begin
						cmd.probe_next = 1'b1;
						state_nx       = ST_PRD;
					end
				end
			end
			ST_BRD: state_nx = ST_BCHK;
			ST_BCHK: begin
				if (sts.ent_empty) begin
					state_nx = ST_BEND;
				end else begin
					cmd.shift_move = sts.do_move;
					if (sts.probe_last) begin
						state_nx = ST_BEND;
					end else begin
						cmd.shift_next = 1'b1;
						state_nx       = ST_BRD;
					end
				end
			end
			ST_BEND: begin
				cmd.shift_end  = 1'b1;
				cmd.next_slice = 1'b1;
				state_nx       = ST_RD;
			end
			ST_DONE: begin
				if (!sts.out_busy) begin
					cmd.out_load = 1'b1;
					state_nx     = ST_IDLE;
				end
			end
			default: state_nx = ST_IDLE;
		endcase
	end

endmodule
`default_nettype wire

// ----- sv/counting_bloom_filter_top.sv -----
// Counting bloom filter over a precomputed 64-bit hash. Each input beat (tuser: operation,
// tdata: hash) adds, deletes or checks one key, or does nothing for a no-op, and yields
// one result beat. The hash is cut into CHUNK_STRIDE-bit slices, each naming a counter;
// saturated counters spill into a linear-probed overflow table of OVERFLOW_DEPTH entries.
// Each slice reads its counter in the counter ram, then updates it; the block also
// accepts the beat, finds the end of the slices and hands over the result. A slice whose
// counter is saturated first finds its home slot and then reads and checks one probed
// entry after another; a delete that empties an entry then runs a backward shift over the
// entries that follow it. After reset the block clears both rams over
// max(NUM_POINTS, OVERFLOW_DEPTH) addresses before it takes the first beat; configuration
// is taken at any time.
`default_nettype none
module counting_bloom_filter_top #(
	parameter int NUM_POINTS     = 1024,
	parameter int CHUNK_STRIDE   = 11,
	parameter int OVERFLOW_DEPTH = 64
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          s_tvalid,
	output logic                               s_tready,
	input  wire logic [cbf_pkg::HASH_W-1:0]    s_tdata,   // hash_value
	input  wire logic [cbf_pkg::OP_W-1:0]      s_tuser,   // operation
	output logic                               m_tvalid,
	input  wire logic                          m_tready,
	output logic [cbf_pkg::OUT_W-1:0]          m_tdata,   // present, nonzero_points, overflow_full
	input  wire logic                          cfg_valid,
	output logic                               cfg_ready,
	input  wire logic [cbf_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [cbf_pkg::HB_W-1:0]      cfg_data
);
	import cbf_pkg::*;

	cmd_t    cmd;
	status_t sts;

	cbf_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.sts     (sts),
		.cmd     (cmd)
	);

	cbf_dp #(
		.NUM_POINTS    (NUM_POINTS),
		.CHUNK_STRIDE  (CHUNK_STRIDE),
		.OVERFLOW_DEPTH(OVERFLOW_DEPTH)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.sts      (sts),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

endmodule
`default_nettype wire
